// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a plain property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/lsms_pkg.sv =====
package lsms_pkg;

  localparam int unsigned ACCUM_W = 10;
  localparam int unsigned CYCLES_W = 8;
  localparam int unsigned LINE_W = 8;

  localparam int unsigned DEF_OAM_CLOCKS = 80;
  localparam int unsigned DEF_XFER_CLOCKS = 172;
  localparam int unsigned DEF_HBLANK_CLOCKS = 204;
  localparam int unsigned DEF_LINE_CLOCKS = 456;

  localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] FRAME_LINES = 8'd154;

  // Configuration register indexes.
  localparam logic CFG_HBLANK_IRQ_EN = 1'b0;
  localparam logic CFG_LYC_IRQ_EN = 1'b1;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CYCLES_W-1:0] cycles_elapsed;
    logic                coincidence_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        stat_mode;
    logic [LINE_W-1:0] line_number;
    logic              lcd_stat_irq;
    logic              vblank_irq;
    logic              draw_line;
    logic [LINE_W-1:0] drawn_line;
    logic              draw_sprites;
  } out_item_t;

  typedef struct packed {
    logic hblank_irq_enable;
    logic lyc_irq_enable;
  } cfg_regs_t;

endpackage

// ===== design/lsms_if.sv =====
interface lsms_in_if;
  logic               valid;
  logic               ready;
  lsms_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsms_out_if;
  logic                valid;
  logic                ready;
  lsms_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsms_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/lsms_mod_reduce.sv =====
module lsms_mod_reduce #(
  parameter int unsigned BUDGET = lsms_pkg::DEF_OAM_CLOCKS
) (
  input  logic [lsms_pkg::ACCUM_W-1:0] value,
  output logic [lsms_pkg::ACCUM_W-1:0] remainder,
  output logic                         reached
);

  localparam int unsigned LO_W = 5;
  localparam int unsigned HI_W = lsms_pkg::ACCUM_W - LO_W;
  localparam int unsigned HI_N = 1 << HI_W;
  localparam int unsigned SMALL_N = 1 << (LO_W + 1);

  // Elaboration-time remainder by shift and subtract; only fed constants.
  function automatic logic [lsms_pkg::ACCUM_W-1:0] const_mod(input int unsigned x,
                                                             input int unsigned d);
    int unsigned r;
    r = x;
    if (d != 0) begin
      for (int s = lsms_pkg::ACCUM_W; s >= 0; s--) begin
        if (r >= (d << s)) begin
          r = r - (d << s);
        end
      end
    end
    return r[lsms_pkg::ACCUM_W-1:0];
  endfunction

  // The value splits into a high part, whose remainder comes from a table,
  // and a low part that is added back before a final small reduction.
  logic [lsms_pkg::ACCUM_W-1:0] hi_tab [HI_N];
  logic [lsms_pkg::ACCUM_W:0]   part;

  for (genvar g = 0; g < HI_N; g++) begin : g_hi
    assign hi_tab[g] = const_mod(int'(g) << LO_W, BUDGET);
  end

  assign part = {1'b0, hi_tab[value[lsms_pkg::ACCUM_W-1:LO_W]]}
              + {{(HI_W + 1){1'b0}}, value[LO_W-1:0]};

  if (BUDGET > (1 << LO_W)) begin : g_wide
    // The partial sum stays below twice the budget here.
    assign remainder = (part >= (lsms_pkg::ACCUM_W + 1)'(BUDGET))
                     ? lsms_pkg::ACCUM_W'(part - (lsms_pkg::ACCUM_W + 1)'(BUDGET))
                     : part[lsms_pkg::ACCUM_W-1:0];
  end else begin : g_narrow
    logic [lsms_pkg::ACCUM_W-1:0] lo_tab [SMALL_N];
    for (genvar k = 0; k < SMALL_N; k++) begin : g_lo
      assign lo_tab[k] = const_mod(k, BUDGET);
    end
    assign remainder = lo_tab[part[LO_W:0]];
  end

  assign reached = (value >= lsms_pkg::ACCUM_W'(BUDGET));

endmodule

// ===== design/lsms_step.sv =====
`include "assert_macros.svh"

module lsms_step #(
  parameter int unsigned OAM_CLOCKS    = lsms_pkg::DEF_OAM_CLOCKS,
  parameter int unsigned XFER_CLOCKS   = lsms_pkg::DEF_XFER_CLOCKS,
  parameter int unsigned HBLANK_CLOCKS = lsms_pkg::DEF_HBLANK_CLOCKS,
  parameter int unsigned LINE_CLOCKS   = lsms_pkg::DEF_LINE_CLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  lsms_pkg::in_item_t  item,
  input  lsms_pkg::cfg_regs_t cfg,
  output lsms_pkg::out_item_t result
);

  lsms_pkg::mode_t                phase_r, phase_nxt;
  logic [lsms_pkg::ACCUM_W-1:0]   accum_r, accum_nxt;
  logic [lsms_pkg::LINE_W-1:0]    line_r, line_nxt;

  logic [lsms_pkg::ACCUM_W:0]     sum_wide;
  logic [lsms_pkg::ACCUM_W-1:0]   sum;
  logic [lsms_pkg::LINE_W-1:0]    line_inc;
  logic [lsms_pkg::ACCUM_W-1:0]   rem_oam, rem_xfer, rem_hblank, rem_line;
  logic                           hit_oam, hit_xfer, hit_hblank, hit_line;

  assign sum_wide = {1'b0, accum_r}
                  + {{(lsms_pkg::ACCUM_W + 1 - lsms_pkg::CYCLES_W){1'b0}},
                     item.cycles_elapsed};
  // The accumulator saturates rather than wraps.
  assign sum = sum_wide[lsms_pkg::ACCUM_W] ? '1 : sum_wide[lsms_pkg::ACCUM_W-1:0];
  assign line_inc = line_r + 8'd1;

  lsms_mod_reduce #(.BUDGET(OAM_CLOCKS)) u_red_oam (
    .value(sum), .remainder(rem_oam), .reached(hit_oam)
  );
  lsms_mod_reduce #(.BUDGET(XFER_CLOCKS)) u_red_xfer (
    .value(sum), .remainder(rem_xfer), .reached(hit_xfer)
  );
  lsms_mod_reduce #(.BUDGET(HBLANK_CLOCKS)) u_red_hblank (
    .value(sum), .remainder(rem_hblank), .reached(hit_hblank)
  );
  lsms_mod_reduce #(.BUDGET(LINE_CLOCKS)) u_red_line (
    .value(sum), .remainder(rem_line), .reached(hit_line)
  );

  // Next state. Below the budget the remainder equals the sum itself.
  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    accum_nxt = sum;
    unique case (phase_r)
      lsms_pkg::MODE_OAM: begin
        accum_nxt = rem_oam;
        if (hit_oam) begin
          phase_nxt = lsms_pkg::MODE_XFER;
        end
      end
      lsms_pkg::MODE_XFER: begin
        accum_nxt = rem_xfer;
        if (hit_xfer) begin
          phase_nxt = lsms_pkg::MODE_HBLANK;
        end
      end
      lsms_pkg::MODE_HBLANK: begin
        accum_nxt = rem_hblank;
        if (hit_hblank) begin
          line_nxt  = line_inc;
          phase_nxt = (line_inc == lsms_pkg::VBLANK_LINE) ? lsms_pkg::MODE_VBLANK
                                                         : lsms_pkg::MODE_OAM;
        end
      end
      lsms_pkg::MODE_VBLANK: begin
        accum_nxt = rem_line;
        if (hit_line) begin
          if (line_inc == lsms_pkg::FRAME_LINES) begin
            line_nxt  = '0;
            phase_nxt = lsms_pkg::MODE_OAM;
          end else begin
            line_nxt = line_inc;
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Result fields.
  always_comb begin
    result.stat_mode    = phase_nxt;
    result.line_number  = line_nxt;
    result.lcd_stat_irq = (phase_r == lsms_pkg::MODE_XFER) && hit_xfer &&
                          (cfg.hblank_irq_enable ||
                           (cfg.lyc_irq_enable && item.coincidence_flag));
    result.draw_line    = (phase_r == lsms_pkg::MODE_HBLANK) && hit_hblank;
    result.vblank_irq   = result.draw_line && (line_inc == lsms_pkg::VBLANK_LINE);
    result.drawn_line   = result.draw_line ? line_r : '0;
    result.draw_sprites = (phase_r == lsms_pkg::MODE_VBLANK) && hit_line &&
                          (line_inc == lsms_pkg::FRAME_LINES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lsms_pkg::MODE_OAM;
      accum_r <= '0;
      line_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      line_r  <= line_nxt;
    end
  end

  `ASSERT_ALWAYS(a_line_in_frame, line_r < lsms_pkg::FRAME_LINES, "line counter left the frame")
  `ASSERT_IMPLIES(a_vblank_lines, phase_r == lsms_pkg::MODE_VBLANK, line_r >= lsms_pkg::VBLANK_LINE, "vblank mode on a visible line")
  `ASSERT_IMPLIES(a_visible_lines, phase_r != lsms_pkg::MODE_VBLANK, line_r < lsms_pkg::VBLANK_LINE, "visible mode on a blank line")

endmodule

// ===== design/lcd_scanline_mode_sequencer.sv =====
// Channel   Direction  Payload
// in_chan   sink       cycles_elapsed, coincidence_flag
// out_chan  source     stat_mode, line_number, irq and draw strobes
// cfg_chan  sink       index, data (always ready)
//
// An item is held in the input register and then moves on into the output
// register; one item is taken every cycle while out_chan
// is ready. Reset is synchronous and returns the sequencer to object scan,
// line 0, with an empty accumulator. When the output register is stalled
// the input register still takes one item before in_chan.ready falls.
module lcd_scanline_mode_sequencer #(
  parameter int unsigned OAM_CLOCKS    = lsms_pkg::DEF_OAM_CLOCKS,
  parameter int unsigned XFER_CLOCKS   = lsms_pkg::DEF_XFER_CLOCKS,
  parameter int unsigned HBLANK_CLOCKS = lsms_pkg::DEF_HBLANK_CLOCKS,
  parameter int unsigned LINE_CLOCKS   = lsms_pkg::DEF_LINE_CLOCKS
) (
  input  logic              clk,
  input  logic              rst_n,
  lsms_in_if.sink           in_chan,
  lsms_out_if.source        out_chan,
  lsms_cfg_if.sink          cfg_chan
);

  logic                 in_valid_r;
  lsms_pkg::in_item_t   in_data_r;
  logic                 out_valid_r;
  lsms_pkg::out_item_t  out_data_r;
  lsms_pkg::cfg_regs_t  cfg_r;
  lsms_pkg::out_item_t  step_result;
  logic                 advance;

  // The held item moves on whenever the output register is free or draining.
  assign advance = in_valid_r && (!out_valid_r || out_chan.ready);

  assign in_chan.ready  = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  lsms_step #(
    .OAM_CLOCKS   (OAM_CLOCKS),
    .XFER_CLOCKS  (XFER_CLOCKS),
    .HBLANK_CLOCKS(HBLANK_CLOCKS),
    .LINE_CLOCKS  (LINE_CLOCKS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .item   (in_data_r),
    .cfg    (cfg_r),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_data_r <= in_chan.data;
    end
    if (advance) begin
      out_data_r <= step_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        lsms_pkg::CFG_HBLANK_IRQ_EN: cfg_r.hblank_irq_enable <= cfg_chan.data;
        lsms_pkg::CFG_LYC_IRQ_EN:    cfg_r.lyc_irq_enable    <= cfg_chan.data;
        default:                     cfg_r                   <= cfg_r;
      endcase
    end
  end

endmodule
